// ===== sv/assert_macros.svh =====
// Assertion macros shared by the tracker modules.
// Each macro samples on the rising edge of clock and is off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/arqst_pkg.sv =====
// Shared types and constants of the selective-repeat send tracker.
// Used by arqst_ctrl, arqst_dp and arq_send_tracker; depends on nothing.
package arqst_pkg;

   // Default sizes handed to the top level.
   localparam int TASK_SLOTS_DEF = 4;
   localparam int MAX_FRAGS_DEF  = 16;

   // Field widths.
   localparam int KIND_W     = 2;
   localparam int ID_W       = 32;
   localparam int FC_W       = 5;
   localparam int AI_W       = 16;
   localparam int NOW_W      = 48;
   localparam int EV_W       = 2;
   localparam int FRAG_OUT_W = 4;
   localparam int RETRY_W    = 8;
   localparam int TMO_W      = 15;

   // Request payload layout, lowest bit first.
   localparam int IN_CLIENT_LSB = 0;
   localparam int IN_DATA_LSB   = IN_CLIENT_LSB + ID_W;
   localparam int IN_FC_LSB     = IN_DATA_LSB + ID_W;
   localparam int IN_AI_LSB     = IN_FC_LSB + FC_W;
   localparam int IN_NOW_LSB    = IN_AI_LSB + AI_W;
   localparam int IN_BITS       = IN_NOW_LSB + NOW_W;
   localparam int REQ_DATA_W    = ((IN_BITS + 7) / 8) * 8;

   // Response payload layout, lowest bit first.
   localparam int OUT_CLIENT_LSB = 0;
   localparam int OUT_DATA_LSB   = OUT_CLIENT_LSB + ID_W;
   localparam int OUT_FRAG_LSB   = OUT_DATA_LSB + ID_W;
   localparam int OUT_BITS       = OUT_FRAG_LSB + FRAG_OUT_W;
   localparam int RSP_DATA_W     = ((OUT_BITS + 7) / 8) * 8;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = TMO_W;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RETRIES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_TMO    = 1'd1;
   localparam logic [RETRY_W-1:0]   MAX_RETRIES_RST = 8'd5;
   localparam logic [TMO_W-1:0]     BASE_TMO_RST    = 15'd500;

   localparam int TIMEOUT_CAP = 30000;

   typedef enum logic [KIND_W-1:0] {
      KIND_START = 2'd0,
      KIND_ACK   = 2'd1,
      KIND_TICK  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [EV_W-1:0] {
      EV_SEND = 2'd0,
      EV_DONE = 2'd1,
      EV_FAIL = 2'd2,
      EV_FULL = 2'd3
   } event_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic      capture;
      logic      install;
      logic      ack_wr;
      logic      clr_valid;
      logic      tick_upd;
      logic      emit;
      event_type emit_ev;
      logic      emit_slot;
      logic      emit_frag;
      logic      flush;
      logic      slot_clr;
      logic      slot_inc;
      logic      frag_clr;
      logic      frag_inc;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      kind_type kind;
      logic     hit;
      logic     has_free;
      logic     ack_done;
      logic     tmo_hit;
      logic     miss_none;
      logic     retry_out;
      logic     frag_missing;
      logic     send_last;
      logic     resend_last;
      logic     last_slot;
      logic     can_emit;
      logic     hold_valid;
      logic     out_free;
   } sts_type;

endpackage

// ===== sv/arq_send_tracker.sv =====
// Top level of the selective-repeat send tracker.
// Joins arqst_ctrl and arqst_dp; depends on arqst_pkg.
//
// The block handles one request at a time. A start that installs a task sends
// each of its fragments, a full table or an ack gives at most one result, and
// a tick checks every task slot and walks every fragment of each task that is
// retransmitted. The slot and fragment walk moves at most one result a cycle
// into the output register, and a stalled rsp channel holds it back. The final
// result of a request is held in the hold register until the walk ends, so that
// it carries tlast. A new request is taken while the last result still waits in
// the output register. The table needs no clearing pass after reset.
module arq_send_tracker #(
   parameter int TASK_SLOTS = arqst_pkg::TASK_SLOTS_DEF,
   parameter int MAX_FRAGS  = arqst_pkg::MAX_FRAGS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration writes.
   input  logic                              csr_we,
   input  logic [arqst_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [arqst_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // Requests.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // client_id, data_id, frag_count, acked_index, now_ms, zero padding
   input  logic [arqst_pkg::REQ_DATA_W-1:0]  req_tdata,
   // kind
   input  logic [arqst_pkg::KIND_W-1:0]      req_tuser,
   // Responses.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_client, out_data, frag_to_send, zero padding
   output logic [arqst_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // event_res
   output logic [arqst_pkg::EV_W-1:0]        rsp_tuser,
   output logic                              rsp_tlast
);

   arqst_pkg::cmd_type cmd;
   arqst_pkg::sts_type sts;

   arqst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   arqst_dp #(
      .TASK_SLOTS (TASK_SLOTS),
      .MAX_FRAGS  (MAX_FRAGS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sv/arqst_ctrl.sv =====
// Sequencing controller of the send tracker: decodes each request and walks
// slots and fragments. Depends on arqst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module arqst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  arqst_pkg::sts_type sts,
   output arqst_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SEND,
      ST_TCHK,
      ST_RESEND,
      ST_FLUSH
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   assign req_tready = ready_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_tvalid & ready_ff;
            if (cmd.capture) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (sts.kind)
               arqst_pkg::KIND_START: begin
                  if (sts.hit || sts.has_free) begin
                     cmd.install  = 1'b1;
                     cmd.frag_clr = 1'b1;
                     state_in     = ST_SEND;
                  end else if (sts.can_emit) begin
                     cmd.emit    = 1'b1;
                     cmd.emit_ev = arqst_pkg::EV_FULL;
                     state_in    = ST_FLUSH;
                  end
               end
               arqst_pkg::KIND_ACK: begin
                  if (sts.hit) begin
                     cmd.ack_wr = 1'b1;
                     if (sts.ack_done) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_ev   = arqst_pkg::EV_DONE;
                        cmd.clr_valid = 1'b1;
                     end
                  end
                  state_in = ST_FLUSH;
               end
               arqst_pkg::KIND_TICK: begin
                  cmd.slot_clr = 1'b1;
                  state_in     = ST_TCHK;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SEND: begin
            if (sts.can_emit) begin
               cmd.emit      = 1'b1;
               cmd.emit_ev   = arqst_pkg::EV_SEND;
               cmd.emit_frag = 1'b1;
               if (sts.send_last) begin
                  state_in = ST_FLUSH;
               end else begin
                  cmd.frag_inc = 1'b1;
               end
            end
         end
         ST_TCHK: begin
            priority if (!sts.tmo_hit) begin
               cmd.slot_inc = !sts.last_slot;
               state_in     = sts.last_slot ? ST_FLUSH : ST_TCHK;
            end else if (sts.miss_none || sts.retry_out) begin
               if (sts.can_emit) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_ev   = sts.miss_none ? arqst_pkg::EV_DONE : arqst_pkg::EV_FAIL;
                  cmd.emit_slot = 1'b1;
                  cmd.clr_valid = 1'b1;
                  cmd.slot_inc  = !sts.last_slot;
                  state_in      = sts.last_slot ? ST_FLUSH : ST_TCHK;
               end
            end else begin
               cmd.tick_upd = 1'b1;
               cmd.frag_clr = 1'b1;
               state_in     = ST_RESEND;
            end
         end
         ST_RESEND: begin
            // A fragment that is already acknowledged is stepped over.
            if (!sts.frag_missing || sts.can_emit) begin
               cmd.emit      = sts.frag_missing;
               cmd.emit_ev   = arqst_pkg::EV_SEND;
               cmd.emit_slot = 1'b1;
               cmd.emit_frag = 1'b1;
               if (sts.resend_last) begin
                  cmd.slot_inc = !sts.last_slot;
                  state_in     = sts.last_slot ? ST_FLUSH : ST_TCHK;
               end else begin
                  cmd.frag_inc = 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (!sts.hold_valid) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   `ASSERT_IMPLIES(a_ready_hold_empty, ready_ff, !sts.hold_valid, "ready while a result is held")
   `ASSERT_IMPLIES(a_decode_after_capture, state_ff == ST_DECODE, $past(cmd.capture), "decode without a captured request")

endmodule

// ===== sv/arqst_dp.sv =====
// Datapath of the send tracker: request capture, task table, configuration
// registers, and the held and output result registers. Depends on arqst_pkg.
`include "assert_macros.svh"

module arqst_dp #(
   parameter int TASK_SLOTS = arqst_pkg::TASK_SLOTS_DEF,
   parameter int MAX_FRAGS  = arqst_pkg::MAX_FRAGS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [arqst_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [arqst_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [arqst_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [arqst_pkg::KIND_W-1:0]      req_tuser,
   input  arqst_pkg::cmd_type                cmd,
   output arqst_pkg::sts_type                sts,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [arqst_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [arqst_pkg::EV_W-1:0]        rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int SIDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int FIDX_W = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
   localparam int FCNT_W = $clog2(MAX_FRAGS + 1);
   localparam int ID_W   = arqst_pkg::ID_W;
   localparam int NOW_W  = arqst_pkg::NOW_W;
   localparam int TMO_W  = arqst_pkg::TMO_W;
   localparam int RTY_W  = arqst_pkg::RETRY_W;
   localparam int AI_W   = arqst_pkg::AI_W;
   localparam int FC_W   = arqst_pkg::FC_W;

   // Configuration registers.
   logic [RTY_W-1:0] max_retries_ff, max_retries_in;
   logic [TMO_W-1:0] base_tmo_ff, base_tmo_in;

   // Captured request.
   arqst_pkg::kind_type item_kind_ff, item_kind_in;
   logic [ID_W-1:0]     item_client_ff, item_client_in;
   logic [ID_W-1:0]     item_data_ff, item_data_in;
   logic [FCNT_W-1:0]   item_fc_ff, item_fc_in;
   logic [AI_W-1:0]     item_ai_ff, item_ai_in;
   logic [NOW_W-1:0]    item_now_ff, item_now_in;

   // Task table.
   logic                 valid_ff [TASK_SLOTS];
   logic                 valid_in [TASK_SLOTS];
   logic [ID_W-1:0]      client_ff [TASK_SLOTS];
   logic [ID_W-1:0]      client_in [TASK_SLOTS];
   logic [ID_W-1:0]      data_ff [TASK_SLOTS];
   logic [ID_W-1:0]      data_in [TASK_SLOTS];
   logic [FCNT_W-1:0]    frags_ff [TASK_SLOTS];
   logic [FCNT_W-1:0]    frags_in [TASK_SLOTS];
   logic [MAX_FRAGS-1:0] ack_ff [TASK_SLOTS];
   logic [MAX_FRAGS-1:0] ack_in [TASK_SLOTS];
   logic [RTY_W-1:0]     retry_ff [TASK_SLOTS];
   logic [RTY_W-1:0]     retry_in [TASK_SLOTS];
   logic [NOW_W-1:0]     sent_ff [TASK_SLOTS];
   logic [NOW_W-1:0]     sent_in [TASK_SLOTS];
   logic [TMO_W-1:0]     tmo_ff [TASK_SLOTS];
   logic [TMO_W-1:0]     tmo_in [TASK_SLOTS];

   // Walk counters.
   logic [SIDX_W-1:0] slot_ff, slot_in;
   logic [FIDX_W-1:0] frag_ff, frag_in;

   // Held result, waiting to learn whether it is the last one.
   logic                         hold_valid_ff, hold_valid_in;
   arqst_pkg::event_type         hold_ev_ff, hold_ev_in;
   logic [ID_W-1:0]              hold_client_ff, hold_client_in;
   logic [ID_W-1:0]              hold_data_ff, hold_data_in;
   logic [arqst_pkg::FRAG_OUT_W-1:0] hold_frag_ff, hold_frag_in;

   // Output register.
   logic                         out_valid_ff, out_valid_in;
   arqst_pkg::event_type         out_ev_ff, out_ev_in;
   logic [ID_W-1:0]              out_client_ff, out_client_in;
   logic [ID_W-1:0]              out_data_ff, out_data_in;
   logic [arqst_pkg::FRAG_OUT_W-1:0] out_frag_ff, out_frag_in;
   logic                         out_last_ff, out_last_in;

   logic [FC_W-1:0]      fc_raw;
   logic [FC_W-1:0]      fc_clamp;
   logic [TASK_SLOTS-1:0] match_vec;
   logic [TASK_SLOTS-1:0] free_vec;
   logic [SIDX_W-1:0]    match_idx;
   logic [SIDX_W-1:0]    free_idx;
   logic [SIDX_W-1:0]    tgt_idx;
   logic [FCNT_W-1:0]    tgt_frags;
   logic [MAX_FRAGS-1:0] tgt_all;
   logic [MAX_FRAGS-1:0] ack_mask;
   logic [MAX_FRAGS-1:0] ack_new;
   logic [FCNT_W-1:0]    rd_frags;
   logic [MAX_FRAGS-1:0] rd_missing;
   logic [NOW_W:0]       age;
   logic [TMO_W:0]       tmo_dbl;
   logic [TMO_W-1:0]     tmo_next;
   logic                 out_free;
   logic                 move;

   // Clamp the fragment count of a start into one to MAX_FRAGS.
   always_comb begin
      fc_raw = req_tdata[arqst_pkg::IN_FC_LSB +: FC_W];
      priority if (fc_raw == '0) begin
         fc_clamp = FC_W'(1);
      end else if (fc_raw > FC_W'(MAX_FRAGS)) begin
         fc_clamp = FC_W'(MAX_FRAGS);
      end else begin
         fc_clamp = fc_raw;
      end
   end

   // Key lookup and first free slot, lowest slot first.
   always_comb begin
      match_idx = '0;
      free_idx  = '0;
      for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
         match_vec[i] = valid_ff[i] && (client_ff[i] == item_client_ff)
                        && (data_ff[i] == item_data_ff);
         free_vec[i]  = !valid_ff[i];
         if (match_vec[i]) begin
            match_idx = SIDX_W'(i);
         end
         if (free_vec[i]) begin
            free_idx = SIDX_W'(i);
         end
      end
   end

   assign tgt_idx   = (item_kind_ff == arqst_pkg::KIND_TICK) ? slot_ff
                      : ((|match_vec) ? match_idx : free_idx);
   assign tgt_frags = frags_ff[tgt_idx];

   // A cumulative ack covers every fragment up to acked_index that exists.
   always_comb begin
      for (int b = 0; b < MAX_FRAGS; b++) begin
         tgt_all[b]  = (FCNT_W'(b) < tgt_frags);
         ack_mask[b] = tgt_all[b] && (AI_W'(b) <= item_ai_ff);
      end
      ack_new = ack_ff[tgt_idx] | ack_mask;
   end

   // Timeout check and retransmission set of the slot under walk.
   always_comb begin
      rd_frags = frags_ff[slot_ff];
      for (int b = 0; b < MAX_FRAGS; b++) begin
         rd_missing[b] = (FCNT_W'(b) < rd_frags) && !ack_ff[slot_ff][b];
      end
      age     = {1'b0, item_now_ff} - {1'b0, sent_ff[slot_ff]};
      tmo_dbl = {tmo_ff[slot_ff], 1'b0};
      if (tmo_dbl < (TMO_W + 1)'(arqst_pkg::TIMEOUT_CAP)) begin
         tmo_next = tmo_dbl[TMO_W-1:0];
      end else begin
         tmo_next = TMO_W'(arqst_pkg::TIMEOUT_CAP);
      end
   end

   assign out_free = !out_valid_ff || rsp_tready;
   assign move     = (cmd.emit || cmd.flush) && hold_valid_ff;

   always_comb begin
      sts.kind         = item_kind_ff;
      sts.hit          = |match_vec;
      sts.has_free     = |free_vec;
      sts.ack_done     = &(ack_new | ~tgt_all);
      sts.tmo_hit      = valid_ff[slot_ff] && !age[NOW_W]
                         && (age[NOW_W-1:0] >= NOW_W'(tmo_ff[slot_ff]));
      sts.miss_none    = ~|rd_missing;
      sts.retry_out    = retry_ff[slot_ff] >= max_retries_ff;
      sts.frag_missing = rd_missing[frag_ff];
      sts.send_last    = FCNT_W'(frag_ff) == (item_fc_ff - FCNT_W'(1));
      sts.resend_last  = FCNT_W'(frag_ff) == (rd_frags - FCNT_W'(1));
      sts.last_slot    = slot_ff == SIDX_W'(TASK_SLOTS - 1);
      sts.can_emit     = !hold_valid_ff || out_free;
      sts.hold_valid   = hold_valid_ff;
      sts.out_free     = out_free;
   end

   always_comb begin
      max_retries_in = max_retries_ff;
      base_tmo_in    = base_tmo_ff;
      if (csr_we) begin
         unique case (csr_index)
            arqst_pkg::CSR_MAX_RETRIES: max_retries_in = csr_wdata[RTY_W-1:0];
            arqst_pkg::CSR_BASE_TMO:    base_tmo_in    = csr_wdata[TMO_W-1:0];
            default:                    max_retries_in = max_retries_ff;
         endcase
      end

      item_kind_in   = item_kind_ff;
      item_client_in = item_client_ff;
      item_data_in   = item_data_ff;
      item_fc_in     = item_fc_ff;
      item_ai_in     = item_ai_ff;
      item_now_in    = item_now_ff;
      if (cmd.capture) begin
         item_kind_in   = arqst_pkg::kind_type'(req_tuser);
         item_client_in = req_tdata[arqst_pkg::IN_CLIENT_LSB +: ID_W];
         item_data_in   = req_tdata[arqst_pkg::IN_DATA_LSB +: ID_W];
         item_fc_in     = FCNT_W'(fc_clamp);
         item_ai_in     = req_tdata[arqst_pkg::IN_AI_LSB +: AI_W];
         item_now_in    = req_tdata[arqst_pkg::IN_NOW_LSB +: NOW_W];
      end

      valid_in  = valid_ff;
      client_in = client_ff;
      data_in   = data_ff;
      frags_in  = frags_ff;
      ack_in    = ack_ff;
      retry_in  = retry_ff;
      sent_in   = sent_ff;
      tmo_in    = tmo_ff;
      if (cmd.install) begin
         valid_in[tgt_idx]  = 1'b1;
         client_in[tgt_idx] = item_client_ff;
         data_in[tgt_idx]   = item_data_ff;
         frags_in[tgt_idx]  = item_fc_ff;
         ack_in[tgt_idx]    = '0;
         retry_in[tgt_idx]  = '0;
         sent_in[tgt_idx]   = item_now_ff;
         tmo_in[tgt_idx]    = base_tmo_ff;
      end
      if (cmd.ack_wr) begin
         ack_in[tgt_idx] = ack_new;
      end
      if (cmd.clr_valid) begin
         valid_in[tgt_idx] = 1'b0;
      end
      if (cmd.tick_upd) begin
         retry_in[slot_ff] = retry_ff[slot_ff] + RTY_W'(1);
         sent_in[slot_ff]  = item_now_ff;
         tmo_in[slot_ff]   = tmo_next;
      end

      slot_in = slot_ff;
      if (cmd.slot_clr) begin
         slot_in = '0;
      end else if (cmd.slot_inc) begin
         slot_in = slot_ff + SIDX_W'(1);
      end
      frag_in = frag_ff;
      if (cmd.frag_clr) begin
         frag_in = '0;
      end else if (cmd.frag_inc) begin
         frag_in = frag_ff + FIDX_W'(1);
      end

      // A new result pushes the held one out as not last; a flush marks it last.
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_ev_in     = out_ev_ff;
      out_client_in = out_client_ff;
      out_data_in   = out_data_ff;
      out_frag_in   = out_frag_ff;
      out_last_in   = out_last_ff;
      if (move) begin
         out_valid_in  = 1'b1;
         out_ev_in     = hold_ev_ff;
         out_client_in = hold_client_ff;
         out_data_in   = hold_data_ff;
         out_frag_in   = hold_frag_ff;
         out_last_in   = cmd.flush;
      end

      hold_valid_in  = hold_valid_ff && !move;
      hold_ev_in     = hold_ev_ff;
      hold_client_in = hold_client_ff;
      hold_data_in   = hold_data_ff;
      hold_frag_in   = hold_frag_ff;
      if (cmd.emit) begin
         hold_valid_in  = 1'b1;
         hold_ev_in     = cmd.emit_ev;
         hold_client_in = cmd.emit_slot ? client_ff[slot_ff] : item_client_ff;
         hold_data_in   = cmd.emit_slot ? data_ff[slot_ff] : item_data_ff;
         hold_frag_in   = cmd.emit_frag ? arqst_pkg::FRAG_OUT_W'(frag_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_retries_ff <= arqst_pkg::MAX_RETRIES_RST;
         base_tmo_ff    <= arqst_pkg::BASE_TMO_RST;
         hold_valid_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
         for (int i = 0; i < TASK_SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         max_retries_ff <= max_retries_in;
         base_tmo_ff    <= base_tmo_in;
         hold_valid_ff  <= hold_valid_in;
         out_valid_ff   <= out_valid_in;
         valid_ff       <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_kind_ff   <= item_kind_in;
      item_client_ff <= item_client_in;
      item_data_ff   <= item_data_in;
      item_fc_ff     <= item_fc_in;
      item_ai_ff     <= item_ai_in;
      item_now_ff    <= item_now_in;
      client_ff      <= client_in;
      data_ff        <= data_in;
      frags_ff       <= frags_in;
      ack_ff         <= ack_in;
      retry_ff       <= retry_in;
      sent_ff        <= sent_in;
      tmo_ff         <= tmo_in;
      slot_ff        <= slot_in;
      frag_ff        <= frag_in;
      hold_ev_ff     <= hold_ev_in;
      hold_client_ff <= hold_client_in;
      hold_data_ff   <= hold_data_in;
      hold_frag_ff   <= hold_frag_in;
      out_ev_ff      <= out_ev_in;
      out_client_ff  <= out_client_in;
      out_data_ff    <= out_data_in;
      out_frag_ff    <= out_frag_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ev_ff;
   assign rsp_tlast  = out_last_ff;
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[arqst_pkg::OUT_CLIENT_LSB +: ID_W] = out_client_ff;
      rsp_tdata[arqst_pkg::OUT_DATA_LSB +: ID_W]   = out_data_ff;
      rsp_tdata[arqst_pkg::OUT_FRAG_LSB +: arqst_pkg::FRAG_OUT_W] = out_frag_ff;
   end

   `ASSERT_IMPLIES(a_no_overwrite, cmd.emit && hold_valid_ff, out_free, "result pushed into a busy output register")
   `ASSERT_ALWAYS(a_single_slot_write, !(cmd.install && (cmd.clr_valid || cmd.tick_upd)), "conflicting table writes")

endmodule
